@@ rtl/wtws_pkg.sv @@
// Shared types, codes and helper functions of the wrapped texture walk sampler.
package wtws_pkg;

	localparam int unsigned MAX_TILE_DIM_DEF = 64;
	localparam int unsigned DIM_W            = 7;
	localparam int unsigned CFG_IDX_W        = 2;
	localparam int unsigned CFG_DATA_W       = 7;
	localparam int unsigned MOD_W            = 16;
	localparam int unsigned MOD_CNT_W        = $clog2(MOD_W);

	localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 2'd2;

	localparam logic [DIM_W-1:0] TILE_DIM_RESET = 7'd64;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SET   = 2'd1,
		OP_STEP  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	// Source and target of one remainder job.
	typedef enum logic [2:0] {
		SEL_PX = 3'd0,
		SEL_PY = 3'd1,
		SEL_SX = 3'd2,
		SEL_SY = 3'd3,
		SEL_AX = 3'd4,
		SEL_AY = 3'd5
	} sel_t;

	typedef struct packed {
		logic       load;
		logic       tex_wr;
		logic       div_start;
		logic       div_commit;
		sel_t       div_sel;
		logic       adv_add;
		logic       adv_wrap;
		logic       adv_commit;
		logic       idx_load;
		logic       rd_en;
		logic [1:0] rd_tap;
		logic       lerp1;
		logic       lerp2;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic x_over;
		logic y_over;
		logic bilinear;
		logic out_free;
	} sts_t;

	// Tile dimension as used: zero counts as one, clamp to the store size.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d,
		input int unsigned mx);
		if (d == '0)
			return DIM_W'(1);
		if (32'(d) > mx)
			return DIM_W'(mx);
		return d;
	endfunction

	// a + floor((b - a) * f / 256), stays between a and b.
	function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] f);
		logic signed [8:0]  d;
		logic signed [16:0] p;
		logic signed [9:0]  s;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		p = 17'(d) * 17'($signed({1'b0, f}));
		s = $signed({2'b00, a}) + 10'(p >>> 8);
		return s[7:0];
	endfunction

endpackage

@@ rtl/wtws_if.sv @@
// Item and result channel interfaces of the wrapped texture walk sampler.
interface wtws_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [5:0]         texel_col;
	logic [5:0]         texel_row;
	logic [31:0]        texel_color;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] step_x;
	logic signed [31:0] step_y;

	modport source(output valid, opcode, texel_col, texel_row, texel_color,
		start_x, start_y, step_x, step_y, input ready);
	modport sink(input valid, opcode, texel_col, texel_row, texel_color,
		start_x, start_y, step_x, step_y, output ready);
endinterface

interface wtws_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample_color;

	modport source(output valid, sample_color, input ready);
	modport sink(input valid, sample_color, output ready);
endinterface

@@ rtl/wtws_mod.sv @@
// Bit-serial remainder unit: floor modulo of a signed 16-bit value by a tile size.
module wtws_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wtws_pkg::MOD_W-1:0]    mag,
	input  logic                          neg,
	input  logic [wtws_pkg::DIM_W-1:0]    dvs,
	output logic                          done,
	output logic [wtws_pkg::DIM_W-1:0]    rem
);
	import wtws_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [MOD_W-1:0]     mag_q;
	logic                 neg_q;
	logic [DIM_W-1:0]     dvs_q;
	logic [DIM_W-1:0]     rem_q;
	logic [DIM_W:0]       trial;

	assign trial = {rem_q, mag_q[MOD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MOD_CNT_W'(MOD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle, keep only the partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			neg_q <= neg;
			dvs_q <= dvs;
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= mag_q << 1;
			if (trial >= {1'b0, dvs_q})
				rem_q <= DIM_W'(trial - {1'b0, dvs_q});
			else
				rem_q <= trial[DIM_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = (neg_q && rem_q != '0) ? dvs_q - rem_q : rem_q;

endmodule

@@ rtl/wtws_dp.sv @@
// Datapath: registers, walk arithmetic, texture memory and byte interpolation.
module wtws_dp #(
	parameter int unsigned MAX_TILE_DIM = wtws_pkg::MAX_TILE_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wtws_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wtws_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [5:0]                        texel_col,
	input  logic [5:0]                        texel_row,
	input  logic [31:0]                       texel_color,
	input  logic signed [31:0]                start_x,
	input  logic signed [31:0]                start_y,
	input  logic signed [31:0]                step_x,
	input  logic signed [31:0]                step_y,
	input  wtws_pkg::cmd_t                    cmd,
	output wtws_pkg::sts_t                    sts,
	input  logic                              result_ready,
	output logic                              result_valid,
	output logic [31:0]                       sample_color
);
	import wtws_pkg::*;

	localparam int unsigned IW    = (MAX_TILE_DIM > 1) ? $clog2(MAX_TILE_DIM) : 1;
	localparam int unsigned PW    = IW + 16;
	localparam int unsigned CW    = PW + 8;
	localparam int unsigned DEPTH = MAX_TILE_DIM * MAX_TILE_DIM;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_TILE_DIM);

	// configuration
	logic [DIM_W-1:0] tw_q, th_q;
	logic             filt_q;
	logic [DIM_W-1:0] tw_eff, th_eff;
	logic [CW-1:0]    lim_x, lim_y;

	// captured item
	logic [5:0]  col_q, row_q;
	logic [31:0] color_q;
	logic [31:0] sx_q, sy_q, stx_q, sty_q;

	// walk state
	logic [PW-1:0] pos_x_q, pos_y_q, step_x_q, step_y_q;
	logic [PW:0]   adv_x_q, adv_y_q;
	logic          x_over, y_over;

	// remainder unit
	logic [MOD_W-1:0] mod_mag;
	logic             mod_neg;
	logic [DIM_W-1:0] mod_dvs;
	logic [15:0]      mod_low;
	logic             mod_done;
	logic [DIM_W-1:0] mod_rem;
	logic [PW-1:0]    mod_val;

	// sampling
	logic [IW-1:0] ix_q, iy_q, x1_q, y1_q;
	logic [7:0]    fx_q, fy_q;
	logic [IW-1:0] ix_w, iy_w;
	logic [IW:0]   ix_inc, iy_inc;
	logic [31:0]   mem [DEPTH];
	logic [31:0]   tap_q [4];
	logic          wr_ok;
	logic [AW-1:0] waddr, raddr;
	logic [IW-1:0] rcol, rrow;
	logic [31:0]   top_w, bot_w, mix_w;
	logic [31:0]   top_q, bot_q, res_q;
	logic          out_valid_q;
	logic [31:0]   out_color_q;

	assign tw_eff = eff_dim(tw_q, MAX_TILE_DIM);
	assign th_eff = eff_dim(th_q, MAX_TILE_DIM);
	assign lim_x  = CW'({tw_eff, 16'h0000});
	assign lim_y  = CW'({th_eff, 16'h0000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q   <= TILE_DIM_RESET;
			th_q   <= TILE_DIM_RESET;
			filt_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TILE_WIDTH:  tw_q   <= cfg_wdata;
				CFG_TILE_HEIGHT: th_q   <= cfg_wdata;
				CFG_FILTER_MODE: filt_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q   <= texel_col;
			row_q   <= texel_row;
			color_q <= texel_color;
			sx_q    <= start_x;
			sy_q    <= start_y;
			stx_q   <= step_x;
			sty_q   <= step_y;
		end
	end

	// Operand select for the remainder unit. Reduction splits a Q16 value into
	// a floored integer part, reduced by the tile size, and the untouched fraction.
	always_comb begin
		mod_mag = '0;
		mod_neg = 1'b0;
		mod_dvs = tw_eff;
		mod_low = '0;
		case (cmd.div_sel)
			SEL_PX: begin
				mod_neg = sx_q[31];
				mod_mag = sx_q[31] ? ~sx_q[31:16] + 16'd1 : sx_q[31:16];
				mod_low = sx_q[15:0];
			end
			SEL_PY: begin
				mod_neg = sy_q[31];
				mod_mag = sy_q[31] ? ~sy_q[31:16] + 16'd1 : sy_q[31:16];
				mod_low = sy_q[15:0];
				mod_dvs = th_eff;
			end
			SEL_SX: begin
				mod_neg = stx_q[31];
				mod_mag = stx_q[31] ? ~stx_q[31:16] + 16'd1 : stx_q[31:16];
				mod_low = stx_q[15:0];
			end
			SEL_SY: begin
				mod_neg = sty_q[31];
				mod_mag = sty_q[31] ? ~sty_q[31:16] + 16'd1 : sty_q[31:16];
				mod_low = sty_q[15:0];
				mod_dvs = th_eff;
			end
			SEL_AX: begin
				mod_mag = MOD_W'(adv_x_q[PW:16]);
				mod_low = adv_x_q[15:0];
			end
			SEL_AY: begin
				mod_mag = MOD_W'(adv_y_q[PW:16]);
				mod_low = adv_y_q[15:0];
				mod_dvs = th_eff;
			end
			default: ;
		endcase
	end

	wtws_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.mag    (mod_mag),
		.neg    (mod_neg),
		.dvs    (mod_dvs),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	assign mod_val = PW'({mod_rem, mod_low});
	assign x_over  = CW'(adv_x_q) >= lim_x;
	assign y_over  = CW'(adv_y_q) >= lim_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			step_x_q <= '0;
			step_y_q <= '0;
		end else begin
			if (cmd.div_commit) begin
				case (cmd.div_sel)
					SEL_PX, SEL_AX: pos_x_q  <= mod_val;
					SEL_PY, SEL_AY: pos_y_q  <= mod_val;
					SEL_SX:         step_x_q <= mod_val;
					SEL_SY:         step_y_q <= mod_val;
					default: ;
				endcase
			end
			if (cmd.adv_commit) begin
				if (!x_over)
					pos_x_q <= adv_x_q[PW-1:0];
				if (!y_over)
					pos_y_q <= adv_y_q[PW-1:0];
			end
		end
	end

	// Advance: add, then one compare and subtract.
	always_ff @(posedge clk) begin
		if (cmd.adv_add) begin
			adv_x_q <= {1'b0, pos_x_q} + {1'b0, step_x_q};
			adv_y_q <= {1'b0, pos_y_q} + {1'b0, step_y_q};
		end else if (cmd.adv_wrap) begin
			if (x_over)
				adv_x_q <= (PW+1)'(CW'(adv_x_q) - lim_x);
			if (y_over)
				adv_y_q <= (PW+1)'(CW'(adv_y_q) - lim_y);
		end
	end

	// Integer and fraction taps, +1 neighbors wrap to zero at the tile edge.
	assign ix_w   = pos_x_q[PW-1:16];
	assign iy_w   = pos_y_q[PW-1:16];
	assign ix_inc = {1'b0, ix_w} + 1'b1;
	assign iy_inc = {1'b0, iy_w} + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.idx_load) begin
			ix_q <= ix_w;
			iy_q <= iy_w;
			fx_q <= pos_x_q[15:8];
			fy_q <= pos_y_q[15:8];
			x1_q <= (CW'(ix_inc) == CW'(tw_eff)) ? '0 : ix_inc[IW-1:0];
			y1_q <= (CW'(iy_inc) == CW'(th_eff)) ? '0 : iy_inc[IW-1:0];
		end
	end

	// Texture memory, one access per cycle.
	assign wr_ok = (32'(col_q) < MAX_TILE_DIM) && (32'(row_q) < MAX_TILE_DIM);
	assign waddr = AW'(row_q) * ROW_STRIDE + AW'(col_q);
	assign rcol  = cmd.rd_tap[0] ? x1_q : ix_q;
	assign rrow  = cmd.rd_tap[1] ? y1_q : iy_q;
	assign raddr = AW'(rrow) * ROW_STRIDE + AW'(rcol);

	always_ff @(posedge clk) begin
		if (cmd.tex_wr && wr_ok)
			mem[waddr] <= color_q;
		if (cmd.rd_en)
			tap_q[cmd.rd_tap] <= mem[raddr];
	end

	always_comb begin
		for (int s = 0; s < 4; s++) begin
			top_w[8*s +: 8] = lerp8(tap_q[0][8*s +: 8], tap_q[1][8*s +: 8], fx_q);
			bot_w[8*s +: 8] = lerp8(tap_q[2][8*s +: 8], tap_q[3][8*s +: 8], fx_q);
			mix_w[8*s +: 8] = lerp8(top_q[8*s +: 8], bot_q[8*s +: 8], fy_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lerp1) begin
			top_q <= top_w;
			bot_q <= bot_w;
		end
		if (cmd.lerp2)
			res_q <= filt_q ? mix_w : tap_q[0];
		if (cmd.out_load)
			out_color_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (result_ready)
			out_valid_q <= 1'b0;
	end

	assign result_valid = out_valid_q;
	assign sample_color = out_color_q;

	assign sts.div_done = mod_done;
	assign sts.x_over   = x_over;
	assign sts.y_over   = y_over;
	assign sts.bilinear = filt_q;
	assign sts.out_free = !out_valid_q || result_ready;

endmodule

@@ rtl/wtws_ctrl.sv @@
// Controller: sequences item acceptance, walk reduction, advance, fetch and filter.
module wtws_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic [1:0]     item_opcode,
	output logic           item_ready,
	output wtws_pkg::cmd_t cmd,
	input  wtws_pkg::sts_t sts
);
	import wtws_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_WRITE = 12'b0000_0000_0010,
		ST_DIVGO = 12'b0000_0000_0100,
		ST_DIVWT = 12'b0000_0000_1000,
		ST_ADD   = 12'b0000_0001_0000,
		ST_WRAP  = 12'b0000_0010_0000,
		ST_CHK   = 12'b0000_0100_0000,
		ST_IDX   = 12'b0000_1000_0000,
		ST_READ  = 12'b0001_0000_0000,
		ST_LERP1 = 12'b0010_0000_0000,
		ST_LERP2 = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t     state_q, state_d;
	sel_t       sel_q, sel_d;
	logic [1:0] rtap_q, rtap_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= SEL_PX;
			rtap_q  <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			rtap_q  <= rtap_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		rtap_d      = rtap_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		cmd.rd_tap  = rtap_q;
		item_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					case (item_opcode)
						OP_WRITE: state_d = ST_WRITE;
						OP_SET: begin
							sel_d   = SEL_PX;
							state_d = ST_DIVGO;
						end
						OP_STEP:  state_d = ST_ADD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_WRITE: begin
				cmd.tex_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVWT;
			end
			ST_DIVWT: begin
				if (sts.div_done) begin
					cmd.div_commit = 1'b1;
					state_d        = ST_DIVGO;
					case (sel_q)
						SEL_PX: sel_d = SEL_PY;
						SEL_PY: sel_d = SEL_SX;
						SEL_SX: sel_d = SEL_SY;
						SEL_SY: state_d = ST_IDLE;
						SEL_AX: begin
							if (sts.y_over)
								sel_d = SEL_AY;
							else
								state_d = ST_IDX;
						end
						default: state_d = ST_IDX;
					endcase
				end
			end
			ST_ADD: begin
				cmd.adv_add = 1'b1;
				state_d     = ST_WRAP;
			end
			ST_WRAP: begin
				cmd.adv_wrap = 1'b1;
				state_d      = ST_CHK;
			end
			ST_CHK: begin
				// still outside a shrunk tile: reduce by the remainder unit
				cmd.adv_commit = 1'b1;
				if (sts.x_over) begin
					sel_d   = SEL_AX;
					state_d = ST_DIVGO;
				end else if (sts.y_over) begin
					sel_d   = SEL_AY;
					state_d = ST_DIVGO;
				end else begin
					state_d = ST_IDX;
				end
			end
			ST_IDX: begin
				cmd.idx_load = 1'b1;
				rtap_d       = '0;
				state_d      = ST_READ;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				if (!sts.bilinear || rtap_q == 2'd3) begin
					rtap_d  = '0;
					state_d = ST_LERP1;
				end else begin
					rtap_d = rtap_q + 2'd1;
				end
			end
			ST_LERP1: begin
				cmd.lerp1 = 1'b1;
				state_d   = ST_LERP2;
			end
			ST_LERP2: begin
				cmd.lerp2 = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/wrapped_texture_walk_sampler_top.sv @@
// Wrapped texture walk sampler top level: channels, configuration port, controller and datapath.
//
// A tiling texture sampler. Opcode 0 writes one 32-bit RGBA texel into a
// MAX_TILE_DIM x MAX_TILE_DIM store (address row * MAX_TILE_DIM + col; writes
// outside the store are dropped). Opcode 1 sets the walk: start and step, signed
// Q16, are each reduced into the current tile by floor modulo. Opcode 2 advances
// the position by the step with one compare and subtract per axis, then samples
// the texel (filter_mode 0) or interpolates the four neighbors with 8-bit
// fractions (filter_mode 1), the +1 neighbors wrapping to zero at the tile edge.
// Only opcode 2 yields a result item; opcode 3 is ignored. Items are handled
// one at a time; a finished result waits in an output register while the next
// item is taken. A step with bilinear sampling reads its four neighbors in
// turn, the texture memory giving one texel per cycle; a set-walk reduces
// its four values in turn in the bit-serial remainder unit (16 steps plus
// hand-off per value). A step taken after the tile was shrunk may need a
// full reduction per axis as well. Configuration must be written only
// while no item is in flight; the block itself does not enforce this.
// Texels never written read as unknown data.
module wrapped_texture_walk_sampler_top #(
	parameter int unsigned MAX_TILE_DIM = wtws_pkg::MAX_TILE_DIM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wtws_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wtws_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	wtws_item_if.sink                        item,
	wtws_result_if.source                    result
);
	import wtws_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic ready_w;

	// Hold ready only while the controller sits idle.
	assign item.ready = ready_w;

	wtws_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_opcode (item.opcode),
		.item_ready  (ready_w),
		.cmd         (cmd),
		.sts         (sts)
	);

	wtws_dp #(
		.MAX_TILE_DIM (MAX_TILE_DIM)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.texel_col    (item.texel_col),
		.texel_row    (item.texel_row),
		.texel_color  (item.texel_color),
		.start_x      (item.start_x),
		.start_y      (item.start_y),
		.step_x       (item.step_x),
		.step_y       (item.step_y),
		.cmd          (cmd),
		.sts          (sts),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.sample_color (result.sample_color)
	);

endmodule

@@ tb/wrapped_texture_walk_sampler_top_test.sv @@
`timescale 1ns / 100ps
// Testbench for the wrapped texture walk sampler: random walks checked against a built-in predictor.

module wrapped_texture_walk_sampler_top_test;

	import wtws_pkg::*;

	typedef struct {
		opcode_t     op;
		bit [5:0]    col;
		bit [5:0]    row;
		bit [31:0]   color;
		bit [31:0]   sx;
		bit [31:0]   sy;
		bit [31:0]   dx;
		bit [31:0]   dy;
	} walk_item_t;

	// Predicts sampled colors from the accepted items and checks the returned ones.
	class sample_scoreboard;
		localparam int unsigned TEX_DIM   = MAX_TILE_DIM_DEF;
		localparam int unsigned TEX_WORDS = TEX_DIM * TEX_DIM;

		logic [31:0] texels [TEX_WORDS];
		bit          written [TEX_WORDS];
		bit [31:0]   pos_x, pos_y, step_x, step_y;
		bit [6:0]    tile_w, tile_h;
		bit          bilinear;
		logic [31:0] expected_samples [$];
		int unsigned n_errors, n_checked;

		function new();
			pos_x = 0;
			pos_y = 0;
			step_x = 0;
			step_y = 0;
			tile_w = TILE_DIM_RESET;
			tile_h = TILE_DIM_RESET;
			bilinear = 1'b0;
			n_errors = 0;
			n_checked = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TILE_WIDTH: tile_w = data;
				CFG_TILE_HEIGHT: tile_h = data;
				CFG_FILTER_MODE: bilinear = data[0];
				default: ;
			endcase
		endfunction

		function int unsigned used_dim(bit [6:0] d);
			if (d == 0)
				return 1;
			if (d > TEX_DIM)
				return TEX_DIM;
			return 32'(d);
		endfunction

		function bit [31:0] floor_mod(bit [31:0] raw, bit [31:0] lim);
			longint v, m;
			v = longint'(signed'(raw));
			m = v % longint'(lim);
			if (m < 0)
				m += longint'(lim);
			return m[31:0];
		endfunction

		function bit [31:0] advance(bit [31:0] pos, bit [31:0] stp, bit [31:0] lim);
			bit [31:0] p;
			p = pos + stp;
			if (p >= lim)
				p -= lim;
			if (p >= lim)
				p = p % lim;
			return p;
		endfunction

		// Addresses of the four taps; nearest mode repeats the base texel.
		function void tap_addrs(input bit [31:0] px, input bit [31:0] py,
			output int unsigned addr[4]);
			int unsigned ix, iy, x1, y1, tw, th;
			tw = used_dim(tile_w);
			th = used_dim(tile_h);
			ix = px >> 16;
			iy = py >> 16;
			x1 = ix;
			y1 = iy;
			if (bilinear) begin
				x1 = (ix + 1 == tw) ? 0 : ix + 1;
				y1 = (iy + 1 == th) ? 0 : iy + 1;
			end
			addr[0] = (iy * TEX_DIM + ix) % TEX_WORDS;
			addr[1] = (iy * TEX_DIM + x1) % TEX_WORDS;
			addr[2] = (y1 * TEX_DIM + ix) % TEX_WORDS;
			addr[3] = (y1 * TEX_DIM + x1) % TEX_WORDS;
		endfunction

		// Taps the next step item will read, without moving the walk.
		function void next_taps(output int unsigned addr[4]);
			bit [31:0] nx, ny;
			nx = advance(pos_x, step_x, used_dim(tile_w) << 16);
			ny = advance(pos_y, step_y, used_dim(tile_h) << 16);
			tap_addrs(nx, ny, addr);
		endfunction

		function int blend8(int a, int b, int f);
			return a + (((b - a) * f) >>> 8);
		endfunction

		function logic [31:0] sample_at(bit [31:0] px, bit [31:0] py);
			int unsigned addr[4];
			logic [31:0] c00, c10, c01, c11, out;
			int top, bot, val;
			tap_addrs(px, py, addr);
			c00 = texels[addr[0]];
			c10 = texels[addr[1]];
			c01 = texels[addr[2]];
			c11 = texels[addr[3]];
			if (!bilinear)
				return c00;
			for (int s = 0; s < 4; s++) begin
				top = blend8(int'(c00[8*s +: 8]), int'(c10[8*s +: 8]), int'(px[15:8]));
				bot = blend8(int'(c01[8*s +: 8]), int'(c11[8*s +: 8]), int'(px[15:8]));
				val = blend8(top, bot, int'(py[15:8]));
				out[8*s +: 8] = val[7:0];
			end
			return out;
		endfunction

		function void note_item(walk_item_t it);
			bit [31:0] limx, limy;
			int unsigned a;
			limx = used_dim(tile_w) << 16;
			limy = used_dim(tile_h) << 16;
			case (it.op)
				OP_WRITE: begin
					a = it.row * TEX_DIM + it.col;
					texels[a] = it.color;
					written[a] = 1'b1;
				end
				OP_SET: begin
					pos_x = floor_mod(it.sx, limx);
					pos_y = floor_mod(it.sy, limy);
					step_x = floor_mod(it.dx, limx);
					step_y = floor_mod(it.dy, limy);
				end
				OP_STEP: begin
					pos_x = advance(pos_x, step_x, limx);
					pos_y = advance(pos_y, step_y, limy);
					expected_samples.push_back(sample_at(pos_x, pos_y));
				end
				default: ;
			endcase
		endfunction

		function void check_sample(logic [31:0] got);
			logic [31:0] want;
			if (expected_samples.size() == 0) begin
				n_errors++;
				$error("sample_color: expected nothing, got %h", got);
				return;
			end
			want = expected_samples.pop_front();
			n_checked++;
			if (got !== want) begin
				n_errors++;
				$error("sample_color: expected %h, got %h", want, got);
			end
		endfunction

		function int unsigned pending();
			return expected_samples.size();
		endfunction
	endclass

	localparam int unsigned WATCHDOG_CYCLES = 2_000_000;
	// Lets a trailing set-walk, which yields no result, or a step after a shrink finish.
	localparam int unsigned DRAIN_CYCLES    = 150;
	localparam int unsigned N_FIXED         = 8;
	localparam int unsigned N_PHASES        = 10;
	localparam int unsigned ITEMS_PER_PHASE = 133;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	wtws_item_if   item_ch();
	wtws_result_if result_ch();

	wrapped_texture_walk_sampler_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item     (item_ch),
		.result   (result_ch)
	);

	sample_scoreboard sb;
	bit               quiet;
	int unsigned      n_items;
	int unsigned      cycles;

	// Tile settings walked through in order: full, single texel, zero and
	// oversized dimensions, odd sizes, and shrinks that leave the walk outside.
	bit [6:0] plan_w [N_FIXED] = '{7'd64, 7'd1, 7'd1, 7'd0,   7'd5, 7'd64, 7'd2,  7'd64};
	bit [6:0] plan_h [N_FIXED] = '{7'd64, 7'd1, 7'd1, 7'd127, 7'd3, 7'd1,  7'd64, 7'd64};
	bit       plan_f [N_FIXED] = '{1'b1,  1'b1, 1'b0, 1'b1,   1'b1, 1'b0,  1'b1,  1'b1};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Pick an idle length: mostly none, some short, a few long; none while quiet.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic bit [31:0] pick_q16();
		int unsigned r;
		bit [31:0] corner [7] = '{32'h0, 32'h1, 32'hffffffff, 32'h80000000,
			32'h7fffffff, 32'h0000ffff, 32'h00010000};
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom();
		if (r < 80)
			return 32'($urandom_range(0, 32'h00800000)) - 32'h00400000;
		return corner[$urandom_range(0, 6)];
	endfunction

	function automatic bit [31:0] pick_color();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 32'h0;
		if (r < 30)
			return 32'hffffffff;
		return $urandom();
	endfunction

	// Fill every field at random; callers then set what the opcode uses.
	function automatic walk_item_t rand_fields(opcode_t op);
		walk_item_t it;
		it.op = op;
		it.col = 6'($urandom_range(0, 63));
		it.row = 6'($urandom_range(0, 63));
		it.color = $urandom();
		it.sx = $urandom();
		it.sy = $urandom();
		it.dx = $urandom();
		it.dy = $urandom();
		return it;
	endfunction

	// Offer one item, hold it until taken, then record it.
	task automatic send_item(input walk_item_t it);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= it.op;
		item_ch.texel_col <= it.col;
		item_ch.texel_row <= it.row;
		item_ch.texel_color <= it.color;
		item_ch.start_x <= it.sx;
		item_ch.start_y <= it.sy;
		item_ch.step_x <= it.dx;
		item_ch.step_y <= it.dy;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(it);
		n_items++;
	endtask

	task automatic send_write(input bit [5:0] col, input bit [5:0] row, input bit [31:0] color);
		walk_item_t it;
		it = rand_fields(OP_WRITE);
		it.col = col;
		it.row = row;
		it.color = color;
		send_item(it);
	endtask

	task automatic start_walk(input bit [31:0] sx, input bit [31:0] sy,
		input bit [31:0] dx, input bit [31:0] dy);
		walk_item_t it;
		it = rand_fields(OP_SET);
		it.sx = sx;
		it.sy = sy;
		it.dx = dx;
		it.dy = dy;
		send_item(it);
	endtask

	// Fill any texel the next step would read before it was ever written, then step.
	task automatic step_and_sample();
		int unsigned taps[4];
		sb.next_taps(taps);
		foreach (taps[k])
			if (!sb.written[taps[k]])
				send_write(6'(taps[k] % 64), 6'(taps[k] / 64), pick_color());
		send_item(rand_fields(OP_STEP));
	endtask

	// Hold write enable across all three registers so it never drops and rises in one step.
	task automatic write_tile_regs(input bit [6:0] w, input bit [6:0] h, input bit [6:0] fdata);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TILE_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		sb.set_reg(CFG_TILE_WIDTH, w);
		cfg_index <= CFG_TILE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		sb.set_reg(CFG_TILE_HEIGHT, h);
		cfg_index <= CFG_FILTER_MODE;
		cfg_wdata <= fdata;
		@(posedge clk);
		sb.set_reg(CFG_FILTER_MODE, fdata);
		cfg_we <= 1'b0;
	endtask

	// Drop valid, wait for every sample, then let a trailing set-walk finish.
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Send about count items, fill writes included.
	task automatic random_phase(input int unsigned count);
		int unsigned r;
		int unsigned first;
		walk_item_t it;
		first = n_items;
		// Step first so a shrunk tile meets a walk left from the old one.
		repeat (3) step_and_sample();
		while (n_items - first < count) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				it = rand_fields(OP_WRITE);
				it.color = pick_color();
				send_item(it);
			end else if (r < 22) begin
				start_walk(pick_q16(), pick_q16(), pick_q16(), pick_q16());
			end else if (r < 25) begin
				send_item(rand_fields(OP_NOP));
			end else begin
				step_and_sample();
			end
		end
	endtask

	// Accept results with random stalls of their own.
	initial begin
		int unsigned hold;
		hold = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_sample(result_ch.sample_color);
	end

	// End the run if the block hangs.
	initial begin
		cycles = 0;
		while (cycles < WATCHDOG_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		bit [6:0] w, h;
		bit       f;
		sb = new();
		quiet = 1'b0;
		n_items = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.opcode <= OP_WRITE;
		item_ch.texel_col <= '0;
		item_ch.texel_row <= '0;
		item_ch.texel_color <= '0;
		item_ch.start_x <= '0;
		item_ch.start_y <= '0;
		item_ch.step_x <= '0;
		item_ch.step_y <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corner texels with extreme colors at reset settings.
		send_write(6'd0, 6'd0, 32'h00000000);
		send_write(6'd63, 6'd63, 32'hffffffff);
		send_write(6'd63, 6'd0, 32'h00ff80ff);
		send_write(6'd0, 6'd63, 32'hff00ff00);
		// Unused opcode: no result, no state change.
		send_item(rand_fields(OP_NOP));
		// Zero walk stays on the origin texel.
		start_walk(32'h0, 32'h0, 32'h0, 32'h0);
		step_and_sample();
		// Step off the right edge and wrap to column zero.
		start_walk(32'h003fffff, 32'h003f8000, 32'h00010000, 32'h0);
		step_and_sample();
		step_and_sample();
		// Most positive and most negative starts and steps.
		start_walk(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h80000000);
		step_and_sample();
		step_and_sample();
		drain();

		// Random phases, one tile setting each; the last ones fully random.
		for (int p = 0; p < N_PHASES; p++) begin
			if (p < N_FIXED) begin
				w = plan_w[p];
				h = plan_h[p];
				f = plan_f[p];
			end else begin
				w = 7'($urandom_range(0, 127));
				h = 7'($urandom_range(0, 127));
				f = 1'($urandom_range(0, 1));
			end
			write_tile_regs(w, h, {6'($urandom_range(0, 63)), f});
			quiet = ($urandom_range(0, 3) == 0);
			random_phase(ITEMS_PER_PHASE);
			quiet = 1'b0;
			drain();
		end

		$display("Covered %0d items over %0d tile settings, nearest and bilinear,",
			n_items, N_PHASES + 1);
		$display("including zero, oversized and shrunk tiles; %0d samples compared, %0d errors.",
			sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
